/* src/assert_macros.svh */
// assertion helpers, empty bodies for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define CSC_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define CSC_ASSERT(lbl, clk, rstn, prop)

`define CSC_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

/* src/csc_pkg.sv */
`default_nettype none

package csc_pkg;

  // quotient bits of the shared divider, enough for results up to 1.0 in q1.15
  localparam int QUOT_W  = 17;
  localparam int STEP_W  = $clog2(QUOT_W);
  localparam int ONE_Q15 = 32768;

  typedef struct packed {
    logic signed [16:0] signal_value;
    logic [15:0]        signal_conf;
    logic [1:0]         combine_method;
    logic               last_signal;
  } in_t;

  typedef struct packed {
    logic signed [16:0] action;
    logic [15:0]        mean_conf;
    logic [1:0]         regime;
    logic               overflow;
  } out_t;

  typedef enum logic [1:0] {
    METHOD_WAVG     = 2'd0,
    METHOD_VOTE     = 2'd1,
    METHOD_ENSEMBLE = 2'd2
  } method_e;

  typedef enum logic [1:0] {
    REGIME_TREND     = 2'd0,
    REGIME_REVERT    = 2'd1,
    REGIME_UNCERTAIN = 2'd2
  } regime_e;

  typedef enum logic {
    CFG_TREND  = 1'b0,
    CFG_REVERT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    DIV_ACTION = 1'b0,
    DIV_MEAN   = 1'b1
  } div_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_LOAD_ACT,
    ST_DIV_ACT,
    ST_TAKE_ACT,
    ST_DIV_MEAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic     load_in;
    logic     accum;
    logic     div_load;
    div_sel_e div_sel;
    logic     div_step;
    logic     take_act;
    logic     set_act_est;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic       last;
    logic [1:0] method;
    logic       div_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/csc_ctrl.sv */
`default_nettype none

module csc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire csc_pkg::sts_t sts_i,
  output csc_pkg::cmd_t      cmd_o
);

  csc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      csc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = csc_pkg::ST_ACCUM;
        end
      end
      csc_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = sts_i.last ? csc_pkg::ST_LOAD_ACT : csc_pkg::ST_IDLE;
      end
      csc_pkg::ST_LOAD_ACT: begin
        cmd_o.div_load = 1'b1;
        if (sts_i.method == csc_pkg::METHOD_ENSEMBLE) begin
          // running estimate is the action, only the mean needs a divide
          cmd_o.set_act_est = 1'b1;
          cmd_o.div_sel     = csc_pkg::DIV_MEAN;
          state_d           = csc_pkg::ST_DIV_MEAN;
        end else begin
          cmd_o.div_sel = csc_pkg::DIV_ACTION;
          state_d       = csc_pkg::ST_DIV_ACT;
        end
      end
      csc_pkg::ST_DIV_ACT: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = csc_pkg::ST_TAKE_ACT;
      end
      csc_pkg::ST_TAKE_ACT: begin
        cmd_o.take_act = 1'b1;
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = csc_pkg::DIV_MEAN;
        state_d        = csc_pkg::ST_DIV_MEAN;
      end
      csc_pkg::ST_DIV_MEAN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = csc_pkg::ST_EMIT;
      end
      csc_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = csc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = csc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/csc_datapath.sv */
`default_nettype none

module csc_datapath #(
  parameter int MAX_SIGNALS = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire csc_pkg::cmd_t cmd_i,
  output csc_pkg::sts_t      sts_o,
  input  wire csc_pkg::in_t  in_data_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output csc_pkg::out_t      out_data_o
);

  localparam int CNT_W  = $clog2(MAX_SIGNALS + 1);
  localparam int CONF_W = 15 + CNT_W;
  localparam int WSUM_W = 31 + CNT_W;
  localparam int NUM_W  = 30 + CNT_W;
  localparam int DSH_W  = CONF_W + csc_pkg::QUOT_W - 1;
  localparam int QW     = csc_pkg::QUOT_W;
  localparam int SW     = csc_pkg::STEP_W;

  // registered input word
  logic signed [16:0] v_q;
  logic [15:0]        c_q;
  logic [1:0]         method_q;
  logic               last_q;

  // set accumulators
  logic [CONF_W-1:0]        conf_q, bull_q, bear_q;
  logic signed [WSUM_W-1:0] wsum_q;
  logic signed [16:0]       est_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     drop_q;

  logic [15:0] trend_q, revert_q;

  // shared divider
  logic [NUM_W-1:0] rem_q;
  logic [DSH_W-1:0] dsh_q;
  logic [QW-1:0]    quo_q;
  logic             neg_q, zero_q;
  logic [SW-1:0]    step_q;

  logic signed [16:0] act_q;
  logic               out_valid_q;
  csc_pkg::out_t      out_q;

  // input clamp
  logic signed [16:0] v_clamp;
  logic [15:0]        c_clamp;

  always_comb begin
    v_clamp = in_data_i.signal_value;
    if (in_data_i.signal_value > 17'sd32768) v_clamp = 17'sd32768;
    if (in_data_i.signal_value < -17'sd32768) v_clamp = -17'sd32768;
    c_clamp = (in_data_i.signal_conf > 16'(csc_pkg::ONE_Q15)) ?
              16'(csc_pkg::ONE_Q15) : in_data_i.signal_conf;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      v_q      <= v_clamp;
      c_q      <= c_clamp;
      method_q <= in_data_i.combine_method;
      last_q   <= in_data_i.last_signal;
    end
  end

  // accumulation terms
  logic signed [16:0] c_s17;
  logic signed [17:0] c_s18, diff;
  logic signed [33:0] prod_w;
  logic signed [35:0] prod_e, prod_adj;
  logic signed [16:0] est_next;
  logic               set_full;

  always_comb begin
    c_s17    = $signed({1'b0, c_q});
    c_s18    = $signed({2'b00, c_q});
    prod_w   = c_s17 * v_q;
    diff     = $signed({v_q[16], v_q}) - $signed({est_q[16], est_q});
    prod_e   = c_s18 * diff;
    // truncate toward zero on the rescale
    prod_adj = prod_e + (prod_e[35] ? 36'sd32767 : 36'sd0);
    // the update can wrap transiently, the sum always lands back in range
    est_next = est_q + $signed(prod_adj[31:15]);
    set_full = (cnt_q >= CNT_W'(MAX_SIGNALS));
  end

  // divider operand selection
  logic [WSUM_W-1:0]      wsum_mag;
  logic signed [CONF_W:0] vote_diff;
  logic [CONF_W:0]        vote_mag;
  logic [NUM_W-1:0]       num_sel;
  logic [CONF_W-1:0]      den_sel;
  logic                   neg_sel;

  always_comb begin
    wsum_mag  = wsum_q[WSUM_W-1] ? WSUM_W'(-wsum_q) : WSUM_W'(wsum_q);
    vote_diff = $signed({1'b0, bull_q}) - $signed({1'b0, bear_q});
    vote_mag  = vote_diff[CONF_W] ? (CONF_W+1)'(-vote_diff) : (CONF_W+1)'(vote_diff);
    num_sel   = NUM_W'(conf_q);
    den_sel   = CONF_W'(cnt_q);
    neg_sel   = 1'b0;
    if (cmd_i.div_sel == csc_pkg::DIV_ACTION) begin
      case (method_q)
        csc_pkg::METHOD_VOTE: begin
          num_sel = {vote_mag[CONF_W-1:0], 15'd0};
          den_sel = bull_q + bear_q;
          neg_sel = vote_diff[CONF_W];
        end
        default: begin
          num_sel = wsum_mag[NUM_W-1:0];
          den_sel = conf_q;
          neg_sel = wsum_q[WSUM_W-1];
        end
      endcase
    end
  end

  logic             div_ge;
  logic [QW-1:0]    q_mag, q_clamp;
  logic signed [16:0] q_signed;

  always_comb begin
    div_ge   = (DSH_W'(rem_q) >= dsh_q);
    q_mag    = zero_q ? '0 : quo_q;
    q_clamp  = (q_mag > QW'(csc_pkg::ONE_Q15)) ? QW'(csc_pkg::ONE_Q15) : q_mag;
    q_signed = neg_q ? -$signed(17'(q_clamp)) : $signed(17'(q_clamp));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= num_sel;
      dsh_q  <= DSH_W'(den_sel) << (QW - 1);
      quo_q  <= '0;
      neg_q  <= neg_sel;
      zero_q <= (den_sel == '0);
      step_q <= SW'(QW - 1);
    end else if (cmd_i.div_step) begin
      if (div_ge) rem_q <= rem_q - NUM_W'(dsh_q);
      quo_q  <= {quo_q[QW-2:0], div_ge};
      dsh_q  <= dsh_q >> 1;
      // the count rests at zero after the last step
      if (step_q != '0) step_q <= step_q - SW'(1);
    end
    if (cmd_i.set_act_est) begin
      act_q <= est_q;
    end else if (cmd_i.take_act) begin
      act_q <= q_signed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= '0;
      bull_q <= '0;
      bear_q <= '0;
      wsum_q <= '0;
      est_q  <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.emit) begin
      conf_q <= '0;
      bull_q <= '0;
      bear_q <= '0;
      wsum_q <= '0;
      est_q  <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.accum) begin
      if (set_full) begin
        drop_q <= 1'b1;
      end else begin
        conf_q <= conf_q + CONF_W'(c_q);
        wsum_q <= wsum_q + WSUM_W'(prod_w);
        if (v_q > 17'sd0) bull_q <= bull_q + CONF_W'(c_q);
        if (v_q < 17'sd0) bear_q <= bear_q + CONF_W'(c_q);
        est_q  <= est_next;
        cnt_q  <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trend_q  <= 16'd19661;
      revert_q <= 16'd6554;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == csc_pkg::CFG_TREND) trend_q <= cfg_wdata_i;
      if (cfg_idx_i == csc_pkg::CFG_REVERT) revert_q <= cfg_wdata_i;
    end
  end

  // regime from the final action
  logic [16:0]       act_mag;
  csc_pkg::regime_e  regime;

  always_comb begin
    act_mag = act_q[16] ? 17'(-act_q) : 17'(act_q);
    if (act_mag > {1'b0, trend_q}) begin
      regime = csc_pkg::REGIME_TREND;
    end else if (act_mag < {1'b0, revert_q}) begin
      regime = csc_pkg::REGIME_REVERT;
    end else begin
      regime = csc_pkg::REGIME_UNCERTAIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // mean quotient is still in the divider when the word goes out
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.action    <= act_q;
      out_q.mean_conf <= q_clamp[15:0];
      out_q.regime    <= regime;
      out_q.overflow  <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.last     = last_q;
  assign sts_o.method   = method_q;
  assign sts_o.div_last = (step_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

/* src/confidence_weighted_signal_combiner.sv */
// channel | dir | handshake               | word
// in      | in  | in_valid_i / in_stall_o | csc_pkg::in_t  (value, conf, method, last)
// out     | out | out_valid_o/out_stall_i | csc_pkg::out_t (action, mean, regime, ovf)
// cfg     | in  | cfg_we_i                | cfg_idx_i selects threshold, cfg_wdata_i
//
// a word that does not end a set is registered at the input, then accumulated
// a last word then goes through the shared serial divider, which runs once
// for the action (skipped in ensemble mode) and once for the mean
// reset clears accumulators and loads the default thresholds, no clearing pass
// the output register frees the input side; only a held result blocks the next emit
`default_nettype none

`include "assert_macros.svh"

module confidence_weighted_signal_combiner #(
  parameter int MAX_SIGNALS = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire csc_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output csc_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [15:0]   cfg_wdata_i
);

  csc_pkg::cmd_t cmd;
  csc_pkg::sts_t sts;

  csc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csc_datapath #(
    .MAX_SIGNALS (MAX_SIGNALS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // an accepted word must be accumulated before the next one comes in
  `CSC_ASSERT(a_accept_then_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // never overwrite a result the sink has not taken
  `CSC_ASSERT_NEVER(a_no_result_loss, clk_i, rst_ni, cmd.emit && out_valid_o && out_stall_i)

  // divider load and step are exclusive
  `CSC_ASSERT_NEVER(a_div_exclusive, clk_i, rst_ni, cmd.div_load && cmd.div_step)

  // a result only follows a divide that has run to its last step
  `CSC_ASSERT(a_emit_after_div, clk_i, rst_ni, cmd.emit |-> sts.div_last)

endmodule

`default_nettype wire

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAPACITY = 256;
  localparam int SETTLE_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER_RESULTS = 30;
  localparam logic [1:0] METHOD_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  csc_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  csc_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  csc_pkg::cfg_idx_e cfg_idx_i = csc_pkg::CFG_TREND;
  logic [15:0] cfg_wdata_i = '0;

  confidence_weighted_signal_combiner #(
    .MAX_SIGNALS(SET_CAPACITY)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  csc_pkg::in_t signal_queue[$];
  csc_pkg::out_t expected_fusions[$];
  int errors = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  // predictor state
  logic [15:0] trend_level = 16'd19661;
  logic [15:0] revert_level = 16'd6554;
  logic [24:0] conf_sum = '0;
  logic signed [41:0] weighted_sum = '0;
  logic [24:0] bull_sum = '0;
  logic [24:0] bear_sum = '0;
  logic signed [16:0] estimate = '0;
  logic [8:0] set_count = '0;
  logic set_dropped = 1'b0;

  function automatic longint limit_unit(longint a);
    if (a > csc_pkg::ONE_Q15) return csc_pkg::ONE_Q15;
    if (a < -csc_pkg::ONE_Q15) return -csc_pkg::ONE_Q15;
    return a;
  endfunction

  function void combine_signal(input csc_pkg::in_t w);
    longint v;
    longint c;
    longint est;
    longint total;
    longint act;
    longint mean;
    longint mag;
    csc_pkg::out_t r;
    v = longint'(w.signal_value);
    c = longint'(w.signal_conf);
    if (v > csc_pkg::ONE_Q15) v = csc_pkg::ONE_Q15;
    if (v < -csc_pkg::ONE_Q15) v = -csc_pkg::ONE_Q15;
    if (c > csc_pkg::ONE_Q15) c = csc_pkg::ONE_Q15;
    if (set_count >= SET_CAPACITY) begin
      set_dropped = 1'b1;
    end else begin
      conf_sum = conf_sum + 25'(c);
      weighted_sum = weighted_sum + 42'(c * v);
      if (v > 0) bull_sum = bull_sum + 25'(c);
      else if (v < 0) bear_sum = bear_sum + 25'(c);
      est = longint'(estimate);
      estimate = 17'(est + (c * (v - est)) / csc_pkg::ONE_Q15);
      set_count = set_count + 9'd1;
    end
    if (!w.last_signal) return;
    act = 0;
    mean = 0;
    if (w.combine_method == csc_pkg::METHOD_VOTE) begin
      total = longint'(bull_sum) + longint'(bear_sum);
      if (total > 0)
        act = limit_unit(((longint'(bull_sum) - longint'(bear_sum)) * csc_pkg::ONE_Q15)
                         / total);
    end else if (w.combine_method == csc_pkg::METHOD_ENSEMBLE) begin
      act = limit_unit(longint'(estimate));
    end else if (conf_sum != 0) begin
      act = limit_unit(longint'(weighted_sum) / longint'(conf_sum));
    end
    if (set_count != 0) mean = longint'(conf_sum) / longint'(set_count);
    if (mean > csc_pkg::ONE_Q15) mean = csc_pkg::ONE_Q15;
    mag = (act < 0) ? -act : act;
    r.action = 17'(act);
    r.mean_conf = 16'(mean);
    if (mag > longint'(trend_level)) r.regime = csc_pkg::REGIME_TREND;
    else if (mag < longint'(revert_level)) r.regime = csc_pkg::REGIME_REVERT;
    else r.regime = csc_pkg::REGIME_UNCERTAIN;
    r.overflow = set_dropped;
    expected_fusions.insert(expected_fusions.size(), r);
    conf_sum = '0;
    weighted_sum = '0;
    bull_sum = '0;
    bear_sum = '0;
    estimate = '0;
    set_count = '0;
    set_dropped = 1'b0;
  endfunction

  // checker and predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == csc_pkg::CFG_TREND) trend_level = cfg_wdata_i;
        else revert_level = cfg_wdata_i;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_fusions.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %p", $time, out_data_o);
          errors++;
        end else begin
          csc_pkg::out_t e;
          e = expected_fusions[0];
          expected_fusions.delete(0);
          if (out_data_o.action !== e.action) begin
            $display("%0t: action mismatch, expected %0d, got %0d",
                     $time, e.action, out_data_o.action);
            errors++;
          end
          if (out_data_o.mean_conf !== e.mean_conf) begin
            $display("%0t: mean_conf mismatch, expected %0d, got %0d",
                     $time, e.mean_conf, out_data_o.mean_conf);
            errors++;
          end
          if (out_data_o.regime !== e.regime) begin
            $display("%0t: regime mismatch, expected %0d, got %0d",
                     $time, e.regime, out_data_o.regime);
            errors++;
          end
          if (out_data_o.overflow !== e.overflow) begin
            $display("%0t: overflow mismatch, expected %0d, got %0d",
                     $time, e.overflow, out_data_o.overflow);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) combine_signal(in_data_i);
    end
  end

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0 || signal_queue.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= signal_queue[0];
        signal_queue.delete(0);
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: rotating stall patterns plus one long hold-off
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  bit held_once = 1'b0;
  logic next_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      hold_left <= 0;
      rx_cycle <= 0;
      held_once <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      case (stall_mode)
        1: next_stall = ($urandom_range(0, 3) == 0);
        2: next_stall = ($urandom_range(0, 3) != 0);
        3: next_stall = ((rx_cycle % 8) < 5);
        default: next_stall = 1'b0;
      endcase
      if (!held_once && results_seen >= HOLD_AFTER_RESULTS) begin
        held_once <= 1'b1;
        hold_left <= LONG_HOLD;
        next_stall = 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        next_stall = (hold_left != 1);
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      out_stall_i <= next_stall;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic void push_word(int v, int c, logic [1:0] m, bit last);
    csc_pkg::in_t w;
    w.signal_value = 17'(v);
    w.signal_conf = 16'(c);
    w.combine_method = m;
    w.last_signal = last;
    signal_queue.insert(signal_queue.size(), w);
  endfunction

  function automatic csc_pkg::in_t random_word(bit last);
    csc_pkg::in_t w;
    int v;
    int c;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = int'($urandom_range(0, 131071)) - 65536;
      2: v = ($urandom_range(0, 1) == 1) ? csc_pkg::ONE_Q15 : -csc_pkg::ONE_Q15;
      default: v = int'($urandom_range(0, 65536)) - csc_pkg::ONE_Q15;
    endcase
    case ($urandom_range(0, 7))
      0: c = 0;
      1: c = $urandom_range(0, 65535);
      2: c = csc_pkg::ONE_Q15;
      default: c = $urandom_range(0, csc_pkg::ONE_Q15);
    endcase
    w.signal_value = 17'(v);
    w.signal_conf = 16'(c);
    w.combine_method = 2'($urandom_range(0, 3));
    w.last_signal = last;
    return w;
  endfunction

  function automatic void queue_random_sets(int n);
    int done;
    int len;
    done = 0;
    while (done < n) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        signal_queue.insert(signal_queue.size(), random_word(i == len - 1));
      done += len;
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (signal_queue.size() != 0 || in_valid_i || expected_fusions.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(csc_pkg::cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= 16'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned trend, int unsigned revert, int n);
    wait_idle();
    write_threshold(csc_pkg::CFG_TREND, trend);
    write_threshold(csc_pkg::CFG_REVERT, revert);
    queue_random_sets(n);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // clamped extremes, single-word sets
    push_word(65535, 65535, csc_pkg::METHOD_WAVG, 1'b1);
    push_word(-65536, csc_pkg::ONE_Q15, csc_pkg::METHOD_VOTE, 1'b1);
    // zero total confidence
    push_word(1000, 0, csc_pkg::METHOD_WAVG, 1'b1);
    // zero values count for neither side of the vote
    push_word(0, 20000, csc_pkg::METHOD_ENSEMBLE, 1'b0);
    push_word(0, 30000, csc_pkg::METHOD_VOTE, 1'b1);
    push_word(20000, 16384, csc_pkg::METHOD_VOTE, 1'b0);
    push_word(-30000, csc_pkg::ONE_Q15, csc_pkg::METHOD_WAVG, 1'b0);
    push_word(12000, 8000, csc_pkg::METHOD_ENSEMBLE, 1'b1);
    // unused mode falls back to weighted mean
    push_word(5000, 10000, csc_pkg::METHOD_ENSEMBLE, 1'b0);
    push_word(-7000, 20000, METHOD_UNUSED, 1'b1);
    push_word(15000, 9000, csc_pkg::METHOD_WAVG, 1'b0);
    push_word(-4000, 3000, METHOD_UNUSED, 1'b0);
    push_word(0, csc_pkg::ONE_Q15, csc_pkg::METHOD_VOTE, 1'b1);
    // regime boundaries at the default thresholds
    push_word(19661, csc_pkg::ONE_Q15, csc_pkg::METHOD_WAVG, 1'b1);
    push_word(19662, csc_pkg::ONE_Q15, csc_pkg::METHOD_WAVG, 1'b1);
    push_word(6554, csc_pkg::ONE_Q15, csc_pkg::METHOD_WAVG, 1'b1);
    push_word(6553, csc_pkg::ONE_Q15, csc_pkg::METHOD_WAVG, 1'b1);
    push_word(-6553, csc_pkg::ONE_Q15, csc_pkg::METHOD_ENSEMBLE, 1'b1);
    push_word(-20000, 40000, csc_pkg::METHOD_VOTE, 1'b0);
    push_word(30000, 65535, csc_pkg::METHOD_WAVG, 1'b1);

    run_phase($urandom_range(16384, 26000), $urandom_range(2000, 9000), 200);
    // set runs past capacity, the closing word is dropped too
    for (int i = 0; i < SET_CAPACITY + 2; i++)
      signal_queue.insert(signal_queue.size(), random_word(i == SET_CAPACITY + 1));
    run_phase(0, 0, 95);
    run_phase(csc_pkg::ONE_Q15, csc_pkg::ONE_Q15, 95);
    run_phase(csc_pkg::ONE_Q15, 0, 95);
    run_phase(0, csc_pkg::ONE_Q15, 95);
    run_phase($urandom_range(0, csc_pkg::ONE_Q15), $urandom_range(0, csc_pkg::ONE_Q15), 95);
    wait_idle();

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/csc_pkg.sv
src/csc_ctrl.sv
src/csc_datapath.sv
src/confidence_weighted_signal_combiner.sv
sim/tb.sv
